/* sv/ip4_pkg.sv */
// Shared mode codes and sample widths for the intra 4x4 luma predictor.
package ip4_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned AboveW  = 8 * SampleW;
  localparam int unsigned LeftW   = 4 * SampleW;
  localparam int unsigned HalfW   = 8 * SampleW;
  localparam logic [SampleW-1:0] DcDefault = 8'd128;

  typedef enum logic [3:0] {
    MODE_VERT = 4'd0,
    MODE_HORZ = 4'd1,
    MODE_DC   = 4'd2,
    MODE_DDL  = 4'd3,
    MODE_DDR  = 4'd4,
    MODE_VR   = 4'd5,
    MODE_HD   = 4'd6,
    MODE_VL   = 4'd7,
    MODE_HU   = 4'd8
  } ip4_mode_e;

endpackage

/* sv/intra_4x4_luma_predictor_top.sv */
// Top level of the intra 4x4 luma predictor: input register, datapath, result register.
//
// One item per clock: an item is taken on every rising edge with start high, and
// busy never rises. Each item's predicted 4x4 block passes through the input
// register, the neighbour filters and mode select, and the result register, and
// is shown for exactly one cycle with done_o high. The receiver cannot hold
// results off, so it must capture done_o cycles as they come.
// mode_usable_o is low, and both pixel halves are zero, when the mode's neighbours
// are missing or the mode code is above 8; DC falls back to 128 with no edges.
module intra_4x4_luma_predictor_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [3:0]                 pred_mode_i,
  input  logic                       above_ok_i,
  input  logic                       left_ok_i,
  input  logic                       corner_ok_i,
  input  logic [ip4_pkg::AboveW-1:0] above_row_i,
  input  logic [ip4_pkg::LeftW-1:0]  left_column_i,
  input  logic [7:0]                 corner_pixel_i,
  output logic                       done_o,
  output logic                       mode_usable_o,
  output logic [ip4_pkg::HalfW-1:0]  pred_upper_o,
  output logic [ip4_pkg::HalfW-1:0]  pred_lower_o
);
  import ip4_pkg::*;

  // input register
  logic              in_vld_q;
  logic [3:0]        mode_q;
  logic              above_ok_q;
  logic              left_ok_q;
  logic              corner_ok_q;
  logic [AboveW-1:0] above_q;
  logic [LeftW-1:0]  left_q;
  logic [7:0]        corner_q;

  // result register
  logic              done_q;
  logic              usable_q;
  logic [HalfW-1:0]  upper_q;
  logic [HalfW-1:0]  lower_q;

  logic              usable_d;
  logic [HalfW-1:0]  upper_d;
  logic [HalfW-1:0]  lower_d;
  logic              accept;

  // Never stall: the datapath takes a fresh item every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= accept;
      done_q   <= in_vld_q;
    end
  end

  // Capture the item; payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q      <= pred_mode_i;
      above_ok_q  <= above_ok_i;
      left_ok_q   <= left_ok_i;
      corner_ok_q <= corner_ok_i;
      above_q     <= above_row_i;
      left_q      <= left_column_i;
      corner_q    <= corner_pixel_i;
    end
  end

  ip4_core u_core (
    .pred_mode_i    (mode_q),
    .above_ok_i     (above_ok_q),
    .left_ok_i      (left_ok_q),
    .corner_ok_i    (corner_ok_q),
    .above_row_i    (above_q),
    .left_column_i  (left_q),
    .corner_pixel_i (corner_q),
    .mode_usable_o  (usable_d),
    .pred_upper_o   (upper_d),
    .pred_lower_o   (lower_d)
  );

  // Hold the finished block for its single strobe cycle.
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      usable_q <= usable_d;
      upper_q  <= upper_d;
      lower_q  <= lower_d;
    end
  end

  assign done_o        = done_q;
  assign mode_usable_o = usable_q;
  assign pred_upper_o  = upper_q;
  assign pred_lower_o  = lower_q;

endmodule

/* sv/ip4_core.sv */
// Combinational 4x4 prediction datapath: neighbour filters and per-pixel mode select.
module ip4_core (
  input  logic [3:0]                 pred_mode_i,
  input  logic                       above_ok_i,
  input  logic                       left_ok_i,
  input  logic                       corner_ok_i,
  input  logic [ip4_pkg::AboveW-1:0] above_row_i,
  input  logic [ip4_pkg::LeftW-1:0]  left_column_i,
  input  logic [7:0]                 corner_pixel_i,
  output logic                       mode_usable_o,
  output logic [ip4_pkg::HalfW-1:0]  pred_upper_o,
  output logic [ip4_pkg::HalfW-1:0]  pred_lower_o
);
  import ip4_pkg::*;

  // index 0 holds the corner, then the above row / left column
  logic [71:0]  top_vec;
  logic [39:0]  side_vec;
  logic [9:0]   sum_above;
  logic [9:0]   sum_left;
  logic [10:0]  sum_both;
  logic [7:0]   dc_val;
  logic [127:0] pix_all;

  assign top_vec  = {above_row_i, corner_pixel_i};
  assign side_vec = {left_column_i, corner_pixel_i};

  function automatic logic [7:0] top_at(input logic [71:0] v, input int i);
    int k;
    k = i + 1;
    if (k < 0 || k > 8) return 8'd0;
    return v[8*k +: 8];
  endfunction

  function automatic logic [7:0] side_at(input logic [39:0] v, input int i);
    int k;
    k = i + 1;
    if (k < 0 || k > 4) return 8'd0;
    return v[8*k +: 8];
  endfunction

  function automatic logic [7:0] f2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  function automatic logic [7:0] f3(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
    logic [9:0] s;
    s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
    return s[9:2];
  endfunction

  function automatic logic [7:0] pixel(input logic [3:0] mode, input int x, input int y,
                                       input logic [71:0] t, input logic [39:0] s,
                                       input logic [7:0] dc);
    int z;
    int i;
    logic [7:0] p;
    z = 0;
    i = 0;
    p = 8'd0;
    case (mode)
      MODE_VERT: p = top_at(t, x);
      MODE_HORZ: p = side_at(s, y);
      MODE_DC:   p = dc;
      MODE_DDL: begin
        if (x == 3 && y == 3) p = f3(top_at(t, 6), top_at(t, 7), top_at(t, 7));
        else p = f3(top_at(t, x + y), top_at(t, x + y + 1), top_at(t, x + y + 2));
      end
      MODE_DDR: begin
        if (x > y) p = f3(top_at(t, x - y - 2), top_at(t, x - y - 1), top_at(t, x - y));
        else if (x < y)
          p = f3(side_at(s, y - x - 2), side_at(s, y - x - 1), side_at(s, y - x));
        else p = f3(top_at(t, 0), top_at(t, -1), side_at(s, 0));
      end
      MODE_VR: begin
        z = 2 * x - y;
        i = x - (y >>> 1);
        if (z >= 0 && (z & 1) == 0) p = f2(top_at(t, i - 1), top_at(t, i));
        else if (z >= 0) p = f3(top_at(t, i - 2), top_at(t, i - 1), top_at(t, i));
        else if (z == -1) p = f3(side_at(s, 0), top_at(t, -1), top_at(t, 0));
        else p = f3(side_at(s, y - 1), side_at(s, y - 2), side_at(s, y - 3));
      end
      MODE_HD: begin
        z = 2 * y - x;
        i = y - (x >>> 1);
        if (z >= 0 && (z & 1) == 0) p = f2(side_at(s, i - 1), side_at(s, i));
        else if (z >= 0) p = f3(side_at(s, i - 2), side_at(s, i - 1), side_at(s, i));
        else if (z == -1) p = f3(top_at(t, 0), top_at(t, -1), side_at(s, 0));
        else p = f3(top_at(t, x - 1), top_at(t, x - 2), top_at(t, x - 3));
      end
      MODE_VL: begin
        i = x + (y >>> 1);
        if ((y & 1) == 0) p = f2(top_at(t, i), top_at(t, i + 1));
        else p = f3(top_at(t, i), top_at(t, i + 1), top_at(t, i + 2));
      end
      default: begin
        z = x + 2 * y;
        i = y + (x >>> 1);
        if (z < 5 && (z & 1) == 0) p = f2(side_at(s, i), side_at(s, i + 1));
        else if (z < 5) p = f3(side_at(s, i), side_at(s, i + 1), side_at(s, i + 2));
        else if (z == 5) p = f3(side_at(s, 2), side_at(s, 3), side_at(s, 3));
        else p = side_at(s, 3);
      end
    endcase
    return p;
  endfunction

  // DC: average whichever edges are present
  always_comb begin
    sum_above = {2'b00, above_row_i[7:0]} + {2'b00, above_row_i[15:8]}
              + {2'b00, above_row_i[23:16]} + {2'b00, above_row_i[31:24]};
    sum_left  = {2'b00, left_column_i[7:0]} + {2'b00, left_column_i[15:8]}
              + {2'b00, left_column_i[23:16]} + {2'b00, left_column_i[31:24]};
    sum_both  = {1'b0, sum_above} + {1'b0, sum_left} + 11'd4;
    if (above_ok_i && left_ok_i) dc_val = sum_both[10:3];
    else if (above_ok_i) dc_val = 8'((sum_above + 10'd2) >> 2);
    else if (left_ok_i) dc_val = 8'((sum_left + 10'd2) >> 2);
    else dc_val = DcDefault;
  end

  always_comb begin
    case (pred_mode_i)
      MODE_DC:                      mode_usable_o = 1'b1;
      MODE_VERT, MODE_DDL, MODE_VL: mode_usable_o = above_ok_i;
      MODE_HORZ, MODE_HU:           mode_usable_o = left_ok_i;
      MODE_DDR, MODE_VR, MODE_HD:   mode_usable_o = corner_ok_i;
      default:                      mode_usable_o = 1'b0;
    endcase
  end

  for (genvar k = 0; k < 16; k++) begin : g_pix
    assign pix_all[8*k +: 8] = pixel(pred_mode_i, k % 4, k / 4, top_vec, side_vec, dc_val);
  end

  // drop the prediction when the mode cannot be used
  assign pred_upper_o = mode_usable_o ? pix_all[63:0]   : '0;
  assign pred_lower_o = mode_usable_o ? pix_all[127:64] : '0;

endmodule

/* sv/ip4_checker.sv */
// Port-level checker for the intra 4x4 luma predictor, bound to the top level.
module ip4_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [3:0]                 pred_mode_i,
  input logic                       done_o,
  input logic                       mode_usable_o,
  input logic [ip4_pkg::HalfW-1:0]  pred_upper_o,
  input logic [ip4_pkg::HalfW-1:0]  pred_lower_o
);
  import ip4_pkg::*;

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a matching item");

  a_unusable_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !mode_usable_o) |-> (pred_upper_o == '0 && pred_lower_o == '0))
    else $error("unusable mode returned non-zero pixels");

  a_invalid_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy && (pred_mode_i > MODE_HU), 2) |-> (done_o && !mode_usable_o))
    else $error("invalid mode reported usable");

  a_dc_usable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy && (pred_mode_i == MODE_DC), 2) |-> (done_o && mode_usable_o))
    else $error("DC mode reported unusable");

endmodule

bind intra_4x4_luma_predictor_top ip4_checker u_ip4_checker (.*);
